// File: rtl/tgc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tgc_pkg;

  localparam int DEBOUNCE_W = 10;
  localparam int TIMEOUT_W  = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE  = 2'd0,
    CFG_LONG_PRESS = 2'd1,
    CFG_CLICK_GAP = 2'd2
  } cfg_index_t;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET   = 10'd30;
  localparam logic [TIMEOUT_W-1:0]  LONG_PRESS_RESET = 16'd800;
  localparam logic [TIMEOUT_W-1:0]  CLICK_GAP_RESET  = 16'd400;

  typedef enum logic [2:0] {
    GEST_NONE   = 3'd0,
    GEST_SHORT  = 3'd1,
    GEST_DOUBLE = 3'd2,
    GEST_TRIPLE = 3'd3,
    GEST_LONG   = 3'd4
  } gesture_t;

  localparam logic [1:0] CLICK_MAX = 2'd3;

  typedef struct packed {
    logic [DEBOUNCE_W-1:0] debounce_len;
    logic [TIMEOUT_W-1:0]  long_press_len;
    logic [TIMEOUT_W-1:0]  click_gap_len;
  } tgc_cfg_t;

endpackage
`default_nettype wire

// File: rtl/tgc_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
module tgc_cfg_regs
  import tgc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output tgc_cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_len   <= DEBOUNCE_RESET;
      cfg.long_press_len <= LONG_PRESS_RESET;
      cfg.click_gap_len  <= CLICK_GAP_RESET;
    end else if (wr_en) begin
      case (wr_index)
        CFG_DEBOUNCE:   cfg.debounce_len   <= wr_data[DEBOUNCE_W-1:0];
        CFG_LONG_PRESS: cfg.long_press_len <= wr_data[TIMEOUT_W-1:0];
        CFG_CLICK_GAP:  cfg.click_gap_len  <= wr_data[TIMEOUT_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/tgc_engine.sv
`timescale 1ns / 1ps
`default_nettype none
module tgc_engine
  import tgc_pkg::*;
#(
  parameter int TIME_WIDTH = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     step,
  input  wire logic     level,
  input  wire tgc_cfg_t cfg,
  output gesture_t      gesture_next,
  output logic          pressed_next
);

  localparam int CW = (TIME_WIDTH > TIMEOUT_W) ? TIME_WIDTH : TIMEOUT_W;
  localparam logic [TIME_WIDTH-1:0] TMAX = {TIME_WIDTH{1'b1}};
  localparam logic [TIME_WIDTH-1:0] TONE = TIME_WIDTH'(1);

  logic                  prev_sample;
  logic                  pressed_flag;
  logic                  long_done;
  logic [TIME_WIDTH-1:0] since_edge_ms;
  logic [TIME_WIDTH-1:0] hold_ms;
  logic [TIME_WIDTH-1:0] long_left_ms;
  logic                  long_armed;
  logic [TIME_WIDTH-1:0] gap_left_ms;
  logic                  gap_armed;
  logic [1:0]            clicks;

  logic                  long_done_next;
  logic [TIME_WIDTH-1:0] since_edge_ms_next;
  logic [TIME_WIDTH-1:0] hold_ms_next;
  logic [TIME_WIDTH-1:0] long_left_ms_next;
  logic                  long_armed_next;
  logic [TIME_WIDTH-1:0] gap_left_ms_next;
  logic                  gap_armed_next;
  logic [1:0]            clicks_next;

  logic [CW-1:0]         long_ext;
  logic [CW-1:0]         gap_ext;
  logic [TIME_WIDTH-1:0] long_load;
  logic [TIME_WIDTH-1:0] gap_load;
  logic                  edge_ok;

  // timeouts clamp to the counter range when TIME_WIDTH is narrow
  assign long_ext  = CW'(cfg.long_press_len);
  assign gap_ext   = CW'(cfg.click_gap_len);
  assign long_load = (long_ext > CW'(TMAX)) ? TMAX : long_ext[TIME_WIDTH-1:0];
  assign gap_load  = (gap_ext > CW'(TMAX)) ? TMAX : gap_ext[TIME_WIDTH-1:0];

  always_comb begin
    gesture_next       = GEST_NONE;
    pressed_next       = pressed_flag;
    long_done_next     = long_done;
    long_left_ms_next  = long_left_ms;
    long_armed_next    = long_armed;
    gap_left_ms_next   = gap_left_ms;
    gap_armed_next     = gap_armed;
    clicks_next        = clicks;
    since_edge_ms_next = (since_edge_ms == TMAX) ? TMAX : since_edge_ms + TONE;
    hold_ms_next       = (hold_ms == TMAX) ? TMAX : hold_ms + TONE;

    // timers first
    if (long_armed) begin
      if (long_left_ms <= TONE) begin
        long_left_ms_next = '0;
        long_armed_next   = 1'b0;
        if (pressed_flag && !long_done) begin
          if (level) begin
            long_done_next = 1'b1;
            gesture_next   = GEST_LONG;
          end else begin
            pressed_next = 1'b0;
          end
        end
      end else begin
        long_left_ms_next = long_left_ms - TONE;
      end
    end

    if (gap_armed) begin
      if (gap_left_ms <= TONE) begin
        gap_left_ms_next = '0;
        gap_armed_next   = 1'b0;
        clicks_next      = '0;
        // a long press in the same tick wins; series closes silently
        if (gesture_next == GEST_NONE) begin
          case (clicks)
            2'd1:    gesture_next = GEST_SHORT;
            2'd2:    gesture_next = GEST_DOUBLE;
            2'd3:    gesture_next = GEST_TRIPLE;
            default: gesture_next = GEST_NONE;
          endcase
        end
      end else begin
        gap_left_ms_next = gap_left_ms - TONE;
      end
    end

    // then the edge, against the already advanced timers
    edge_ok = (level != prev_sample) &&
              (CW'(since_edge_ms_next) >= CW'(cfg.debounce_len));
    if (edge_ok) begin
      since_edge_ms_next = '0;
      if (level) begin
        pressed_next      = 1'b1;
        long_done_next    = 1'b0;
        hold_ms_next      = '0;
        gap_armed_next    = 1'b0;
        gap_left_ms_next  = '0;
        long_armed_next   = 1'b1;
        long_left_ms_next = long_load;
      end else begin
        pressed_next      = 1'b0;
        long_armed_next   = 1'b0;
        long_left_ms_next = '0;
        if (!long_done_next && (CW'(hold_ms_next) >= CW'(cfg.debounce_len))) begin
          if (clicks_next != CLICK_MAX) begin
            clicks_next = clicks_next + 2'd1;
          end
          gap_armed_next   = 1'b1;
          gap_left_ms_next = gap_load;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sample   <= 1'b0;
      pressed_flag  <= 1'b0;
      long_done     <= 1'b0;
      since_edge_ms <= TMAX;
      hold_ms       <= '0;
      long_left_ms  <= '0;
      long_armed    <= 1'b0;
      gap_left_ms   <= '0;
      gap_armed     <= 1'b0;
      clicks        <= '0;
    end else if (step) begin
      prev_sample   <= level;
      pressed_flag  <= pressed_next;
      long_done     <= long_done_next;
      since_edge_ms <= since_edge_ms_next;
      hold_ms       <= hold_ms_next;
      long_left_ms  <= long_left_ms_next;
      long_armed    <= long_armed_next;
      gap_left_ms   <= gap_left_ms_next;
      gap_armed     <= gap_armed_next;
      clicks        <= clicks_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/touch_gesture_classifier.sv
// A sample accepted into the input register moves on to the result register once that
// register is empty or its beat is being taken (input register, then result register).
// Throughput: one sample per cycle while the sink keeps taking results; the gesture state
// update is a single pass of saturating counters and compares between the two registers.
// Reset (synchronous, active high): empties both registers, clears the gesture state
// and loads debounce 30, long press 800 and click gap 400.
`timescale 1ns / 1ps
`default_nettype none
module touch_gesture_classifier
  import tgc_pkg::*;
#(
  parameter int TIME_WIDTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  pin_level,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [2:0]                 gesture,
  output logic                       is_pressed
);

  tgc_cfg_t cfg;
  logic     s1_valid;
  logic     s1_level;
  logic     advance;
  logic     step;
  gesture_t eng_gesture;
  logic     eng_pressed;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign in_ready  = !s1_valid || advance;
  assign step      = s1_valid && advance;

  tgc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  tgc_engine #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .level        (s1_level),
    .cfg          (cfg),
    .gesture_next (eng_gesture),
    .pressed_next (eng_pressed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_level <= pin_level;
    end
  end

  // result register; holds the beat while the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
    if (step) begin
      gesture    <= eng_gesture;
      is_pressed <= eng_pressed;
    end
  end

endmodule
`default_nettype wire

// File: rtl/tgc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module tgc_checker
  import tgc_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] gesture,
  input wire logic       is_pressed
);

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result beat right after reset");

  // a long press is only reported while the pad is held
  a_long_pressed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && gesture == GEST_LONG) |-> is_pressed)
    else $error("long press reported with pressed flag low");

  a_gesture_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (gesture <= GEST_LONG))
    else $error("gesture code out of range");

  // with the result register empty the input stage always moves
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(gesture) && $stable(is_pressed)))
    else $error("stalled result beat changed");

endmodule

bind touch_gesture_classifier tgc_checker u_tgc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .gesture    (gesture),
  .is_pressed (is_pressed)
);
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import tgc_pkg::*;

  localparam int TW = 16;
  localparam logic [TW-1:0] TMAX = '1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
  localparam int LONG_STALL = 300;
  localparam int unsigned CYCLE_LIMIT = 600000;

  typedef struct packed {
    gesture_t gesture;
    logic     pressed;
  } tick_result_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic                  pin_level;
  logic                  out_valid;
  logic                  out_ready;
  logic [2:0]            gesture;
  logic                  is_pressed;

  touch_gesture_classifier uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pin_level(pin_level),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .gesture(gesture),
    .is_pressed(is_pressed)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // gesture predictor state
  logic [DEBOUNCE_W-1:0] deb_ms;
  logic [TIMEOUT_W-1:0]  hold_limit_ms;
  logic [TIMEOUT_W-1:0]  quiet_ms;
  logic                  prev_lvl;
  logic                  pressed;
  logic                  long_fired;
  logic                  long_run;
  logic                  gap_run;
  logic [TW-1:0]         since_edge;
  logic [TW-1:0]         hold_t;
  logic [TW-1:0]         long_left;
  logic [TW-1:0]         gap_left;
  logic [1:0]            n_clicks;

  logic                  touch_samples[$];
  tick_result_t          gesture_fifo[$];
  tick_result_t          head;
  logic                  in_took;
  int                    sender_idle_pct;
  int                    recv_stall_pct;
  int                    stall_reqs;
  int                    stall_served;
  int                    stall_left;
  int                    errors;
  int                    n_samples;
  int                    n_settings;
  int                    seen[5];
  int unsigned           cycles;

  function automatic void reset_predictor();
    deb_ms        = DEBOUNCE_RESET;
    hold_limit_ms = LONG_PRESS_RESET;
    quiet_ms      = CLICK_GAP_RESET;
    prev_lvl      = 1'b0;
    pressed       = 1'b0;
    long_fired    = 1'b0;
    long_run      = 1'b0;
    gap_run       = 1'b0;
    since_edge    = TMAX;
    hold_t        = '0;
    long_left     = '0;
    gap_left      = '0;
    n_clicks      = '0;
  endfunction

  function automatic tick_result_t classify_tick(input logic lvl);
    tick_result_t r;
    logic [1:0] n;
    r.gesture = GEST_NONE;
    if (since_edge != TMAX) since_edge = since_edge + 1'b1;
    if (hold_t != TMAX) hold_t = hold_t + 1'b1;
    if (long_run) begin
      if (long_left <= 1) begin
        long_left = '0;
        long_run = 1'b0;
        if (pressed && !long_fired) begin
          if (lvl) begin
            long_fired = 1'b1;
            r.gesture = GEST_LONG;
          end else begin
            pressed = 1'b0;
          end
        end
      end else begin
        long_left = long_left - 1'b1;
      end
    end
    if (gap_run) begin
      if (gap_left <= 1) begin
        n = n_clicks;
        gap_left = '0;
        gap_run = 1'b0;
        n_clicks = '0;
        // a long press in the same tick wins, the series closes silently
        if (r.gesture == GEST_NONE) begin
          case (n)
            2'd1: r.gesture = GEST_SHORT;
            2'd2: r.gesture = GEST_DOUBLE;
            2'd3: r.gesture = GEST_TRIPLE;
            default: r.gesture = GEST_NONE;
          endcase
        end
      end else begin
        gap_left = gap_left - 1'b1;
      end
    end
    if (lvl != prev_lvl && since_edge >= deb_ms) begin
      since_edge = '0;
      if (lvl) begin
        pressed = 1'b1;
        long_fired = 1'b0;
        hold_t = '0;
        gap_run = 1'b0;
        gap_left = '0;
        long_run = 1'b1;
        long_left = hold_limit_ms;
      end else begin
        pressed = 1'b0;
        long_run = 1'b0;
        long_left = '0;
        if (!long_fired && hold_t >= deb_ms) begin
          if (n_clicks != CLICK_MAX) n_clicks = n_clicks + 1'b1;
          gap_run = 1'b1;
          gap_left = quiet_ms;
        end
      end
    end
    prev_lvl = lvl;
    r.pressed = pressed;
    return r;
  endfunction

  // sample driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (touch_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_valid <= 1'b1;
        pin_level <= touch_samples.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver; a long hold-off is counted here
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_served != stall_reqs) begin
      stall_served <= stall_served + 1;
      stall_left <= LONG_STALL;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // predict on accepted samples, check accepted results
  always @(posedge clk) begin
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        gesture_fifo.push_back(classify_tick(pin_level));
        n_samples++;
      end
      if (out_valid && out_ready) begin
        if (gesture_fifo.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, expected none, got gesture %0d pressed %0b",
                   $time, gesture, is_pressed);
        end else begin
          head = gesture_fifo.pop_front();
          if (gesture !== head.gesture) begin
            errors++;
            $display("%0t: gesture mismatch, expected %0d, got %0d",
                     $time, head.gesture, gesture);
          end
          if (is_pressed !== head.pressed) begin
            errors++;
            $display("%0t: is_pressed mismatch, expected %0b, got %0b",
                     $time, head.pressed, is_pressed);
          end
          if (gesture <= GEST_LONG) seen[gesture]++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still owed", $time, gesture_fifo.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DEBOUNCE:   deb_ms = val[DEBOUNCE_W-1:0];
      CFG_LONG_PRESS: hold_limit_ms = val;
      CFG_CLICK_GAP:  quiet_ms = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input int deb, input int lp, input int gap);
    write_reg(CFG_DEBOUNCE, CFG_DATA_W'(deb));
    write_reg(CFG_LONG_PRESS, CFG_DATA_W'(lp));
    write_reg(CFG_CLICK_GAP, CFG_DATA_W'(gap));
    n_settings++;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (touch_samples.size() != 0 || in_valid || gesture_fifo.size() != 0);
  endtask

  task automatic add_run(input logic lvl, input int len);
    repeat (len) touch_samples.push_back(lvl);
  endtask

  // mostly well-formed click series and long holds, some bounce noise
  task automatic add_random_gestures(input int n, input int deb, input int lp, input int gap);
    int base;
    int kind;
    int k;
    base = touch_samples.size();
    while (touch_samples.size() - base < n) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++) begin
          add_run(1'b1, $urandom_range(deb, deb + lp));
          if (i != k - 1) add_run(1'b0, $urandom_range(deb, deb + gap));
        end
        add_run(1'b0, deb + gap + $urandom_range(1, 10));
      end else if (kind < 8) begin
        add_run(1'b1, deb + lp + $urandom_range(0, 10));
        add_run(1'b0, deb + gap + $urandom_range(1, 5));
      end else if (kind == 8) begin
        repeat ($urandom_range(2, 12)) add_run(1'($urandom_range(0, 1)), $urandom_range(1, 3));
      end else begin
        add_run(1'b1, $urandom_range(1, deb + 1));
        add_run(1'b0, $urandom_range(1, deb + 2));
      end
    end
  endtask

  task automatic set_idling(input int sender_pct, input int recv_pct);
    sender_idle_pct = sender_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    int deb;
    int lp;
    int gap;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    pin_level = 1'b0;
    out_ready = 1'b0;
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    stall_reqs = 0;
    stall_served = 0;
    stall_left = 0;
    errors = 0;
    n_samples = 0;
    n_settings = 1;
    cycles = 0;
    for (int i = 0; i < 5; i++) seen[i] = 0;
    reset_predictor();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: a double click, then a long hold
    add_run(1'b1, 40);
    add_run(1'b0, 40);
    add_run(1'b1, 40);
    add_run(1'b0, 410);
    add_run(1'b1, 805);
    add_run(1'b0, 35);
    drain();

    // press whose release bounces away, so the long timer expires with the pin low
    configure(6, 4, 3);
    add_run(1'b1, 2);
    add_run(1'b0, 8);
    // held past the long timeout, release then gives no click
    add_run(1'b1, 7);
    add_run(1'b0, 3);
    drain();

    // zero timeouts behave as one tick, spare index is ignored
    configure(0, 0, 0);
    write_reg(CFG_SPARE_IDX, '1);
    add_run(1'b1, 1);
    add_run(1'b0, 2);
    add_run(1'b1, 1);
    add_run(1'b0, 1);
    add_run(1'b1, 1);
    add_run(1'b0, 2);
    drain();

    // all-ones data: debounce masked to its maximum, longest timeouts
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_random_gestures(100, 2, 10, 5);
    drain();

    configure(0, 1, 1);
    set_idling(70, 70);
    add_random_gestures(120, 1, 4, 3);
    drain();

    for (int p = 0; p < 8; p++) begin
      deb = $urandom_range(0, 6);
      lp = $urandom_range(1, 40);
      gap = $urandom_range(1, 30);
      if (p == 5) begin
        deb = 10;
        lp = 6;
      end
      configure(deb, lp, gap);
      case (p % 4)
        0: set_idling(0, 0);
        1: set_idling(70, 0);
        2: set_idling(0, 70);
        default: set_idling(11, 11);
      endcase
      // receiver holds off while samples keep coming, so the block backs up
      if (p == 0) stall_reqs = stall_reqs + 1;
      add_random_gestures(25, deb, lp, gap);
      drain();
    end

    repeat (10) @(posedge clk);
    $display("Checked %0d touch samples under %0d register settings", n_samples, n_settings);
    $display("Gestures seen: %0d short, %0d double, %0d triple, %0d long",
             seen[GEST_SHORT], seen[GEST_DOUBLE], seen[GEST_TRIPLE], seen[GEST_LONG]);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/tgc_pkg.sv
rtl/tgc_cfg_regs.sv
rtl/tgc_engine.sv
rtl/touch_gesture_classifier.sv
rtl/tgc_checker.sv
tb/tb.sv
